@@ hw/rtl/atp_pkg.sv @@
// atp_pkg: shared types, constants and the arctangent rom of the phase block
// no dependencies

package atp_pkg;

    localparam int unsigned DivSteps = 8;

    localparam logic signed [15:0] PhaseHalf    = 16'sd23040;
    localparam logic signed [15:0] PhaseQuarter = 16'sd11520;
    localparam logic        [14:0] AngQuarter   = 15'd11520;
    localparam logic        [14:0] AngOctant    = 15'd5760;
    localparam logic        [7:0]  IdxMax       = 8'd255;

    // how the first-octant angle is formed
    typedef enum logic [2:0] {
        K_FIXED = 3'd0,   // phase already known (zero operand or axis)
        K_LOW   = 3'd1,   // below the diagonal, rom[q]
        K_HIGH  = 3'd2,   // above the diagonal, rom[q] + 45 degrees
        K_SAT   = 3'd3,   // on the diagonal, rom[255]
        K_STEEP = 3'd4    // near the y axis, 90 degrees
    } t_kind;

    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic                xneg;
        logic                yneg;
        logic signed [15:0]  fixed;
        logic        [16:0]  rem;
        logic        [16:0]  den;
        logic        [7:0]   quo;
    } t_pipe;

    // arctangent in degrees scaled by 1024
    localparam logic [15:0] ArctRom [256] = '{
        16'd0, 16'd229, 16'd458, 16'd687, 16'd916, 16'd1145, 16'd1374, 16'd1603,
        16'd1832, 16'd2061, 16'd2290, 16'd2519, 16'd2748, 16'd2976, 16'd3205, 16'd3433,
        16'd3662, 16'd3890, 16'd4118, 16'd4346, 16'd4574, 16'd4802, 16'd5029, 16'd5257,
        16'd5484, 16'd5711, 16'd5938, 16'd6165, 16'd6391, 16'd6618, 16'd6844, 16'd7070,
        16'd7296, 16'd7521, 16'd7746, 16'd7971, 16'd8196, 16'd8421, 16'd8645, 16'd8869,
        16'd9093, 16'd9317, 16'd9540, 16'd9763, 16'd9986, 16'd10208, 16'd10431, 16'd10652,
        16'd10874, 16'd11095, 16'd11316, 16'd11537, 16'd11757, 16'd11977, 16'd12197,
        16'd12416,
        16'd12635, 16'd12853, 16'd13071, 16'd13289, 16'd13507, 16'd13724, 16'd13940,
        16'd14157,
        16'd14373, 16'd14588, 16'd14803, 16'd15018, 16'd15232, 16'd15446, 16'd15660,
        16'd15873,
        16'd16085, 16'd16297, 16'd16509, 16'd16720, 16'd16931, 16'd17142, 16'd17352,
        16'd17561,
        16'd17770, 16'd17979, 16'd18187, 16'd18394, 16'd18601, 16'd18808, 16'd19014,
        16'd19220,
        16'd19425, 16'd19630, 16'd19834, 16'd20038, 16'd20241, 16'd20444, 16'd20646,
        16'd20848,
        16'd21049, 16'd21250, 16'd21450, 16'd21649, 16'd21848, 16'd22047, 16'd22245,
        16'd22443,
        16'd22640, 16'd22836, 16'd23032, 16'd23227, 16'd23422, 16'd23616, 16'd23810,
        16'd24003,
        16'd24196, 16'd24388, 16'd24580, 16'd24771, 16'd24961, 16'd25151, 16'd25340,
        16'd25529,
        16'd25717, 16'd25905, 16'd26092, 16'd26278, 16'd26464, 16'd26649, 16'd26834,
        16'd27018,
        16'd27202, 16'd27385, 16'd27568, 16'd27750, 16'd27931, 16'd28112, 16'd28292,
        16'd28471,
        16'd28650, 16'd28829, 16'd29007, 16'd29184, 16'd29361, 16'd29537, 16'd29712,
        16'd29887,
        16'd30062, 16'd30236, 16'd30409, 16'd30582, 16'd30754, 16'd30925, 16'd31096,
        16'd31266,
        16'd31436, 16'd31605, 16'd31774, 16'd31942, 16'd32109, 16'd32276, 16'd32442,
        16'd32608,
        16'd32773, 16'd32938, 16'd33101, 16'd33265, 16'd33428, 16'd33590, 16'd33751,
        16'd33913,
        16'd34073, 16'd34233, 16'd34392, 16'd34551, 16'd34709, 16'd34867, 16'd35024,
        16'd35180,
        16'd35336, 16'd35492, 16'd35646, 16'd35801, 16'd35954, 16'd36107, 16'd36260,
        16'd36412,
        16'd36563, 16'd36714, 16'd36864, 16'd37014, 16'd37163, 16'd37312, 16'd37460,
        16'd37607,
        16'd37754, 16'd37901, 16'd38047, 16'd38192, 16'd38337, 16'd38481, 16'd38624,
        16'd38768,
        16'd38910, 16'd39052, 16'd39194, 16'd39335, 16'd39475, 16'd39615, 16'd39754,
        16'd39893,
        16'd40032, 16'd40169, 16'd40307, 16'd40443, 16'd40580, 16'd40715, 16'd40850,
        16'd40985,
        16'd41119, 16'd41253, 16'd41386, 16'd41519, 16'd41651, 16'd41782, 16'd41913,
        16'd42044,
        16'd42174, 16'd42303, 16'd42432, 16'd42561, 16'd42689, 16'd42817, 16'd42944,
        16'd43070,
        16'd43196, 16'd43322, 16'd43447, 16'd43572, 16'd43696, 16'd43819, 16'd43943,
        16'd44065,
        16'd44188, 16'd44309, 16'd44431, 16'd44551, 16'd44672, 16'd44792, 16'd44911,
        16'd45030,
        16'd45148, 16'd45266, 16'd45384, 16'd45501, 16'd45618, 16'd45734, 16'd45849,
        16'd45965
    };

endpackage

@@ hw/rtl/atp_if.sv @@
// atp_in_if / atp_out_if: valid-ready channels of the phase block
// no dependencies

interface atp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] imag_part;
    logic signed [15:0] real_part;

    modport source (output valid, output imag_part, output real_part, input ready);
    modport sink   (input valid, input imag_part, input real_part, output ready);
endinterface

interface atp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] phase_angle;

    modport source (output valid, output phase_angle, input ready);
    modport sink   (input valid, input phase_angle, output ready);
endinterface

@@ hw/rtl/atp_prep.sv @@
// atp_prep: first stage, magnitudes, octant classification, divider operands
// depends on atp_pkg

module atp_prep import atp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_imag,
    input  logic signed [15:0] i_real,
    output t_pipe              o_pipe
);

    t_pipe       r_pipe, n_pipe;
    logic [16:0] ay, ax, sum_yx, dif_yx;
    logic        yneg, xneg;

    always_comb begin
        yneg   = i_imag[15];
        xneg   = i_real[15];
        // unsigned magnitudes, the most negative value gives 32768
        ay     = yneg ? (17'h10000 - {1'b0, i_imag}) : {1'b0, i_imag};
        ax     = xneg ? (17'h10000 - {1'b0, i_real}) : {1'b0, i_real};
        sum_yx = ay + ax;
        dif_yx = ay - ax;

        n_pipe       = '0;
        n_pipe.valid = i_valid;
        n_pipe.xneg  = xneg;
        n_pipe.yneg  = yneg;
        n_pipe.kind  = K_FIXED;
        if (i_imag == 16'sd0) begin
            n_pipe.fixed = xneg ? PhaseHalf : 16'sd0;
        end else if (i_real == 16'sd0) begin
            n_pipe.fixed = yneg ? -PhaseQuarter : PhaseQuarter;
        end else if (ay == ax) begin
            n_pipe.kind = K_SAT;
        end else if (ay < ax) begin
            n_pipe.kind = K_LOW;
            n_pipe.rem  = ay;
            n_pipe.den  = ax;
        end else if ((ay >> 7) <= ax) begin
            // nested floors of the scaled quotient reduce to (n<<8)/d
            n_pipe.kind = K_HIGH;
            n_pipe.rem  = dif_yx;
            n_pipe.den  = sum_yx;
        end else begin
            n_pipe.kind = K_STEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
        if (i_en) begin
            r_pipe.kind  <= n_pipe.kind;
            r_pipe.xneg  <= n_pipe.xneg;
            r_pipe.yneg  <= n_pipe.yneg;
            r_pipe.fixed <= n_pipe.fixed;
            r_pipe.rem   <= n_pipe.rem;
            r_pipe.den   <= n_pipe.den;
            r_pipe.quo   <= n_pipe.quo;
        end
    end

    assign o_pipe = r_pipe;

endmodule

@@ hw/rtl/atp_div_step.sv @@
// atp_div_step: one registered restoring-division step, one quotient bit
// depends on atp_pkg

module atp_div_step import atp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_pipe,
    output t_pipe o_pipe
);

    t_pipe       r_pipe, n_pipe;
    logic [17:0] trial;

    always_comb begin
        // remainder stays below the divisor, so the doubled value fits 18 bits
        trial  = {i_pipe.rem, 1'b0} - {1'b0, i_pipe.den};
        n_pipe = i_pipe;
        if (!trial[17]) begin
            n_pipe.rem = trial[16:0];
            n_pipe.quo = {i_pipe.quo[6:0], 1'b1};
        end else begin
            n_pipe.rem = {i_pipe.rem[15:0], 1'b0};
            n_pipe.quo = {i_pipe.quo[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
        if (i_en) begin
            r_pipe.kind  <= n_pipe.kind;
            r_pipe.xneg  <= n_pipe.xneg;
            r_pipe.yneg  <= n_pipe.yneg;
            r_pipe.fixed <= n_pipe.fixed;
            r_pipe.rem   <= n_pipe.rem;
            r_pipe.den   <= n_pipe.den;
            r_pipe.quo   <= n_pipe.quo;
        end
    end

    assign o_pipe = r_pipe;

endmodule

@@ hw/rtl/atp_finish.sv @@
// atp_finish: rom lookup, quadrant mapping and the output register
// depends on atp_pkg

module atp_finish import atp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_pipe              i_pipe,
    output logic               o_valid,
    output logic signed [15:0] o_phase
);

    logic               r_valid;
    logic signed [15:0] r_phase, n_phase;
    logic        [7:0]  idx;
    logic        [14:0] rom_ang, ang;
    logic signed [15:0] ang_s;

    always_comb begin
        idx     = (i_pipe.kind == K_SAT) ? IdxMax : i_pipe.quo;
        rom_ang = {2'b00, ArctRom[idx][15:3]};
        unique case (i_pipe.kind)
            K_HIGH:  ang = rom_ang + AngOctant;
            K_STEEP: ang = AngQuarter;
            default: ang = rom_ang;
        endcase
        ang_s = $signed({1'b0, ang});
        if (i_pipe.kind == K_FIXED) begin
            n_phase = i_pipe.fixed;
        end else if (i_pipe.xneg && !i_pipe.yneg) begin
            n_phase = PhaseHalf - ang_s;
        end else if (!i_pipe.xneg && i_pipe.yneg) begin
            n_phase = -ang_s;
        end else if (i_pipe.xneg && i_pipe.yneg) begin
            n_phase = ang_s - PhaseHalf;
        end else begin
            n_phase = ang_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_pipe.valid;
        end
        if (i_en) begin
            r_phase <= n_phase;
        end
    end

    assign o_valid = r_valid;
    assign o_phase = r_phase;

endmodule

@@ hw/rtl/table_atan2_phase_top.sv @@
// table_atan2_phase_top: phase of a complex sample by table arctangent
// depends on atp_pkg, atp_if, atp_prep, atp_div_step, atp_finish

// Returns the phase of (imag_part, real_part) in 1/128 degree, 23040 being
// 180 degrees. One sample is taken every clock unless the output stalls;
// each result reaches the output through ten register stages
// (one operand stage loaded at the transfer edge, eight divider stages giving
// one quotient bit each, one rom and quadrant stage that is also the output
// register). The whole pipeline advances together and holds while a finished
// result waits at the output, so no sample is lost or repeated.

module table_atan2_phase_top import atp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atp_in_if.sink      i_in,
    atp_out_if.source   o_out
);

    logic  adv;
    t_pipe stage [DivSteps+1];

    // pipeline moves when the output slot is free or being emptied
    assign adv        = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    atp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in.valid),
        .i_imag  (i_in.imag_part),
        .i_real  (i_in.real_part),
        .o_pipe  (stage[0])
    );

    // divider chain, msb of the quotient first
    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        atp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_pipe  (stage[g]),
            .o_pipe  (stage[g+1])
        );
    end

    atp_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_pipe  (stage[DivSteps]),
        .o_valid (o_out.valid),
        .o_phase (o_out.phase_angle)
    );

endmodule
